FILE: rtl/core/ngga_pkg.sv
package ngga_pkg;

    // default number of fraction digits kept for position minutes
    localparam int FRACTION_DIGITS_DEF = 5;

    // ascii codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SOUTH = 8'h53;
    localparam logic [7:0] CH_WEST  = 8'h57;

    // prefix matcher codes
    localparam logic [2:0] PFX_LEN  = 3'd6;
    localparam logic [2:0] PFX_LAST = 3'd5;
    localparam logic [2:0] PFX_SKIP = 3'd7;

    // field positions inside a gga sentence
    localparam logic [3:0] FLD_LAT     = 4'd2;
    localparam logic [3:0] FLD_LAT_HEM = 4'd3;
    localparam logic [3:0] FLD_LON     = 4'd4;
    localparam logic [3:0] FLD_LON_HEM = 4'd5;
    localparam logic [3:0] FLD_FIX     = 4'd6;
    localparam logic [3:0] FLD_SATS    = 4'd7;
    localparam logic [3:0] FLD_ALT     = 4'd9;
    localparam logic [3:0] FLD_MAX     = 4'd15;

    // limits
    localparam logic [30:0] LAT_LIMIT  = 31'd900000000;
    localparam logic [30:0] LON_LIMIT  = 31'd1800000000;
    localparam logic [20:0] ALT_LOW    = 21'd100000;
    localparam logic [20:0] ALT_HIGH   = 21'd1000000;
    localparam logic [31:0] ALT_IN_MAX = 32'd100000;
    localparam logic [31:0] FIX_MAX    = 32'd15;
    localparam logic [31:0] SATS_MAX   = 32'd99;
    // integer part at or above this gives at least 181 degrees
    localparam logic [31:0] POS_INT_BIG = 32'd18100;
    localparam logic [31:0] E7_SCALE    = 32'd10000000;

    // control word handed to the position converter
    typedef struct packed {
        logic valid;
        logic lon;
        logic big;
    } ngga_pos_cmd_t;

    // "$GNGGA"
    function automatic logic [7:0] ngga_prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h4E;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [23:0] ngga_pow10(input logic [2:0] k);
        logic [23:0] p;
        unique case (k)
            3'd0: p = 24'd1;
            3'd1: p = 24'd10;
            3'd2: p = 24'd100;
            3'd3: p = 24'd1000;
            3'd4: p = 24'd10000;
            3'd5: p = 24'd100000;
            3'd6: p = 24'd1000000;
            3'd7: p = 24'd10000000;
        endcase
        return p;
    endfunction

    // 1e7 / (60 * 10^fd) reduced to num / den, den is 3, 6 or 60
    function automatic logic [15:0] ngga_ratio_num(input logic [2:0] fd);
        logic [15:0] n;
        unique case (fd)
            3'd1:    n = 16'd50000;
            3'd2:    n = 16'd5000;
            3'd3:    n = 16'd500;
            3'd4:    n = 16'd50;
            3'd5:    n = 16'd5;
            default: n = 16'd1;
        endcase
        return n;
    endfunction

    // den = 2^pre * (3 or 15)
    function automatic logic [1:0] ngga_den_pre_shift(input logic [2:0] fd);
        logic [1:0] s;
        unique case (fd)
            3'd6:    s = 2'd1;
            3'd7:    s = 2'd2;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

    // reciprocal of the odd part, exact for any 32-bit dividend
    function automatic logic [31:0] ngga_den_recip(input logic [2:0] fd);
        return (fd == 3'd7) ? 32'h8888_8889 : 32'hAAAA_AAAB;
    endfunction

    function automatic logic [5:0] ngga_den_post_shift(input logic [2:0] fd);
        return (fd == 3'd7) ? 6'd35 : 6'd33;
    endfunction

endpackage

FILE: rtl/core/ngga_pos_unit.sv
module ngga_pos_unit
    import ngga_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ngga_pos_cmd_t            cmd,
    input  logic [14:0]              cmd_int,
    input  logic [$clog2(10 ** FRACTION_DIGITS)-1:0] cmd_frac,
    input  logic [2:0]               cmd_shift,
    output logic [30:0]              lat_mag,
    output logic [30:0]              lon_mag
);
    localparam int FRAC_W = $clog2(10 ** FRACTION_DIGITS);
    localparam logic [2:0] FD3 = 3'(FRACTION_DIGITS);
    localparam int MINS_W = $clog2(100 * (10 ** FRACTION_DIGITS));
    localparam logic [23:0] P_SCALE = ngga_pow10(FD3);
    localparam logic [15:0] R_NUM = ngga_ratio_num(FD3);
    localparam int PRE_SH = int'(ngga_den_pre_shift(FD3));
    localparam logic [31:0] RECIP = ngga_den_recip(FD3);
    localparam int POST_SH = int'(ngga_den_post_shift(FD3));

    ngga_pos_cmd_t       ctl_reg [6];
    logic [14:0]         i0_reg, i1_reg;
    logic [FRAC_W-1:0]   f0_reg, fs1_reg, fs2_reg;
    logic [2:0]          k0_reg;
    logic [7:0]          q1_reg, q2_reg, q3_reg, q4_reg, q5_reg;
    logic [6:0]          r2_reg;
    logic [MINS_W-1:0]   mins3_reg;
    logic [31:0]         x4_reg;
    logic [63:0]         prod5_reg;
    logic [30:0]         lat_mag_reg, lon_mag_reg;

    logic [27:0]         qmul;
    logic [FRAC_W+23:0]  fmul;
    logic [24:0]         frac_e7;
    logic [31:0]         e7;
    logic [30:0]         limit;
    logic [30:0]         mag_next;

    // control valid bits per stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < 6; s++) ctl_reg[s] <= '0;
        end else begin
            ctl_reg[0] <= cmd;
            for (int s = 1; s < 6; s++) ctl_reg[s] <= ctl_reg[s-1];
        end
    end

    // degrees by reciprocal of 100, fraction scaled to full digit count
    always_comb begin
        qmul = 28'(i0_reg) * 28'd5243;
        fmul = (FRAC_W + 24)'(f0_reg) * (FRAC_W + 24)'(ngga_pow10(k0_reg));
    end

    // final scale, add degrees and saturate
    always_comb begin
        frac_e7 = 25'(prod5_reg >> POST_SH);
        e7 = 32'(q5_reg) * E7_SCALE + 32'(frac_e7);
        limit = ctl_reg[5].lon ? LON_LIMIT : LAT_LIMIT;
        if (ctl_reg[5].big || e7 > 32'(limit)) begin
            mag_next = limit;
        end else begin
            mag_next = 31'(e7);
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        i0_reg    <= cmd_int;
        f0_reg    <= cmd_frac;
        k0_reg    <= cmd_shift;
        q1_reg    <= qmul[26:19];
        i1_reg    <= i0_reg;
        fs1_reg   <= FRAC_W'(fmul);
        r2_reg    <= 7'(i1_reg - 15'(q1_reg) * 15'd100);
        q2_reg    <= q1_reg;
        fs2_reg   <= fs1_reg;
        mins3_reg <= MINS_W'(r2_reg) * MINS_W'(P_SCALE) + MINS_W'(fs2_reg);
        q3_reg    <= q2_reg;
        x4_reg    <= 32'(mins3_reg) * 32'(R_NUM);
        q4_reg    <= q3_reg;
        prod5_reg <= 64'(x4_reg >> PRE_SH) * 64'(RECIP);
        q5_reg    <= q4_reg;
    end

    // stored magnitudes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_mag_reg <= '0;
            lon_mag_reg <= '0;
        end else if (ctl_reg[5].valid) begin
            if (ctl_reg[5].lon) begin
                lon_mag_reg <= mag_next;
            end else begin
                lat_mag_reg <= mag_next;
            end
        end
    end

    assign lat_mag = lat_mag_reg;
    assign lon_mag = lon_mag_reg;

endmodule

FILE: rtl/core/nmea_gga_position_parser_core.sv
// GGA sentence parser: takes one ASCII byte per transfer and gives one result at the CR or
// LF that ends each "$GNGGA" line, with latitude and longitude in 1e-7 degrees, altitude in
// decimetres, fix quality, satellite count and a fix-valid flag. A byte is accepted every
// cycle; the input stalls only while a result waits at the output and a second one is
// finishing or waiting behind it. The result is built once the line's position value has passed
// the six-stage pipeline that turns ddmm.mmmmm into degrees. Empty position fields keep
// earlier values.
module nmea_gga_position_parser_core
    import ngga_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // latitude_e7[30:0], longitude_e7[62:31], altitude_dm[83:63], fix_mode[87:84],
    // satellites[94:88], fix_valid[95]
    output logic [95:0] m_tdata
);
    localparam int FRAC_W = $clog2(10 ** FRACTION_DIGITS);
    localparam logic [2:0] FD3 = 3'(FRACTION_DIGITS);
    localparam int RQ_LAST = 6;

    logic [2:0]         pfx_reg, pfx_next;
    logic               in_gga_reg, in_gga_next;
    logic [3:0]         fld_reg, fld_next;
    logic [31:0]        iacc_reg, iacc_next;
    logic [FRAC_W-1:0]  facc_reg, facc_next;
    logic [2:0]         fcnt_reg, fcnt_next;
    logic [3:0]         fdig_reg, fdig_next;
    logic [2:0]         flags_reg, flags_next;
    logic               lat_neg_reg, lat_neg_next;
    logic               lon_neg_reg, lon_neg_next;
    logic [20:0]        alt_reg, alt_next;
    logic [3:0]         fix_reg, fix_next;
    logic [6:0]         sats_reg, sats_next;
    logic [RQ_LAST:0]   rq_reg;
    logic               m_valid_reg, m_valid_next;
    logic [95:0]        m_data_reg, m_data_next;
    logic               h_valid_reg, h_valid_next;
    logic [95:0]        h_data_reg, h_data_next;

    logic               s_fire;
    logic               do_commit;
    logic               req;
    logic [7:0]         b;
    logic [3:0]         dgt;
    logic [35:0]        iacc_wide;
    logic [20:0]        dm;
    logic               alt_over;
    ngga_pos_cmd_t      pos_cmd;
    logic [30:0]        lat_mag, lon_mag;
    logic [30:0]        lat_out;
    logic [31:0]        lon_out;
    logic [95:0]        res;

    assign b = s_tdata;
    assign s_fire = s_tvalid && s_tready;
    assign s_tready = !h_valid_reg && !(rq_reg[RQ_LAST] && m_valid_reg);
    assign dgt = 4'(b - CH_ZERO);
    assign iacc_wide = 36'(iacc_reg) * 36'd10 + 36'(dgt);

    // byte parser and field commit
    always_comb begin
        pfx_next     = pfx_reg;
        in_gga_next  = in_gga_reg;
        fld_next     = fld_reg;
        iacc_next    = iacc_reg;
        facc_next    = facc_reg;
        fcnt_next    = fcnt_reg;
        fdig_next    = fdig_reg;
        flags_next   = flags_reg;
        lat_neg_next = lat_neg_reg;
        lon_neg_next = lon_neg_reg;
        alt_next     = alt_reg;
        fix_next     = fix_reg;
        sats_next    = sats_reg;
        do_commit    = 1'b0;
        req          = 1'b0;
        pos_cmd      = '0;
        alt_over     = iacc_reg > ALT_IN_MAX;
        dm           = 21'(iacc_reg[16:0]) * 21'd10
                       + ((fcnt_reg != 3'd0) ? 21'(fdig_reg) : 21'd0);

        if (s_fire) begin
            priority if (b == CH_CR || b == CH_LF) begin
                if (in_gga_reg) begin
                    do_commit = 1'b1;
                    req = 1'b1;
                end
                pfx_next    = '0;
                in_gga_next = 1'b0;
                fld_next    = '0;
                iacc_next   = '0;
                facc_next   = '0;
                fcnt_next   = '0;
                flags_next  = '0;
            end else if (!in_gga_reg) begin
                if (pfx_reg < PFX_LEN && b == ngga_prefix_char(pfx_reg)) begin
                    pfx_next = pfx_reg + 3'd1;
                    if (pfx_reg == PFX_LAST) begin
                        in_gga_next = 1'b1;
                        fld_next    = '0;
                        iacc_next   = '0;
                        facc_next   = '0;
                        fcnt_next   = '0;
                        flags_next  = '0;
                    end
                end else begin
                    pfx_next = PFX_SKIP;
                end
            end else if (b == CH_COMMA) begin
                do_commit  = 1'b1;
                fld_next   = (fld_reg < FLD_MAX) ? fld_reg + 4'd1 : fld_reg;
                iacc_next  = '0;
                facc_next  = '0;
                fcnt_next  = '0;
                flags_next = '0;
            end else if (fld_reg == FLD_LAT_HEM || fld_reg == FLD_LON_HEM) begin
                // hemisphere: first byte only
                if (!flags_reg[2]) begin
                    flags_next[2] = 1'b1;
                    if (fld_reg == FLD_LAT_HEM) begin
                        lat_neg_next = (b == CH_SOUTH);
                    end else begin
                        lon_neg_next = (b == CH_WEST);
                    end
                end
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
                if (!flags_reg[0]) begin
                    iacc_next = (iacc_wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : iacc_wide[31:0];
                end else if (fcnt_reg < FD3) begin
                    facc_next = facc_reg * FRAC_W'(10) + FRAC_W'(dgt);
                    if (fcnt_reg == 3'd0) fdig_next = dgt;
                    fcnt_next = fcnt_reg + 3'd1;
                end
                flags_next[1] = 1'b1;
            end else if (b == CH_POINT) begin
                flags_next[0] = 1'b1;
            end else if (b == CH_MINUS) begin
                flags_next[2] = 1'b1;
            end else begin
                // other bytes inside a field are ignored
            end
        end

        // store the finished field
        if (do_commit) begin
            unique case (fld_reg)
                FLD_LAT, FLD_LON: begin
                    if (flags_reg[1]) begin
                        pos_cmd.valid = 1'b1;
                        pos_cmd.lon   = (fld_reg == FLD_LON);
                        pos_cmd.big   = iacc_reg >= POS_INT_BIG;
                        if (fld_reg == FLD_LON) lon_neg_next = 1'b0;
                        else lat_neg_next = 1'b0;
                    end
                end
                FLD_FIX: fix_next = (iacc_reg > FIX_MAX) ? 4'(FIX_MAX) : iacc_reg[3:0];
                FLD_SATS: sats_next = (iacc_reg > SATS_MAX) ? 7'(SATS_MAX) : iacc_reg[6:0];
                FLD_ALT: begin
                    if (flags_reg[2]) begin
                        alt_next = (alt_over || dm > ALT_LOW) ? 21'd0 - ALT_LOW : 21'd0 - dm;
                    end else begin
                        alt_next = (alt_over || dm > ALT_HIGH) ? ALT_HIGH : dm;
                    end
                end
                default: ;
            endcase
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pfx_reg     <= '0;
            in_gga_reg  <= 1'b0;
            fld_reg     <= '0;
            iacc_reg    <= '0;
            facc_reg    <= '0;
            fcnt_reg    <= '0;
            fdig_reg    <= '0;
            flags_reg   <= '0;
            lat_neg_reg <= 1'b0;
            lon_neg_reg <= 1'b0;
            alt_reg     <= '0;
            fix_reg     <= '0;
            sats_reg    <= '0;
            rq_reg      <= '0;
        end else begin
            pfx_reg     <= pfx_next;
            in_gga_reg  <= in_gga_next;
            fld_reg     <= fld_next;
            iacc_reg    <= iacc_next;
            facc_reg    <= facc_next;
            fcnt_reg    <= fcnt_next;
            fdig_reg    <= fdig_next;
            flags_reg   <= flags_next;
            lat_neg_reg <= lat_neg_next;
            lon_neg_reg <= lon_neg_next;
            alt_reg     <= alt_next;
            fix_reg     <= fix_next;
            sats_reg    <= sats_next;
            rq_reg      <= {rq_reg[RQ_LAST-1:0], req};
        end
    end

    // position conversion
    ngga_pos_unit #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_pos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (pos_cmd),
        .cmd_int   (iacc_reg[14:0]),
        .cmd_frac  (facc_reg),
        .cmd_shift (FD3 - fcnt_reg),
        .lat_mag   (lat_mag),
        .lon_mag   (lon_mag)
    );

    // result word once the converter has caught up
    always_comb begin
        lat_out = lat_neg_reg ? 31'd0 - lat_mag : lat_mag;
        lon_out = lon_neg_reg ? 32'd0 - {1'b0, lon_mag} : {1'b0, lon_mag};
        res = {(fix_reg != 4'd0), sats_reg, fix_reg, alt_reg, lon_out, lat_out};
    end

    // output register with one waiting slot
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        h_valid_next = h_valid_reg;
        h_data_next  = h_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = h_valid_reg;
            m_data_next  = h_data_reg;
            h_valid_next = 1'b0;
        end
        if (rq_reg[RQ_LAST]) begin
            if (!m_valid_next) begin
                m_valid_next = 1'b1;
                m_data_next  = res;
            end else begin
                h_valid_next = 1'b1;
                h_data_next  = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            h_valid_reg <= h_valid_next;
        end
        m_data_reg <= m_data_next;
        h_data_reg <= h_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // only one result request in flight
    a_rq_single: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(rq_reg))
        else $error("more than one result request in flight");

    // a finishing request always finds the waiting slot free
    a_rq_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        rq_reg[RQ_LAST] |-> !h_valid_reg)
        else $error("result request met a full waiting slot");

    // waiting slot is used only behind a held output
    a_hold_order: assert property (@(posedge aclk) disable iff (!aresetn)
        h_valid_reg |-> m_valid_reg)
        else $error("waiting slot full with output empty");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import ngga_pkg::*;
();

    // one decoded position result
    typedef struct packed {
        logic        fix_valid;
        logic [6:0]  satellites;
        logic [3:0]  fix_mode;
        logic [20:0] altitude_dm;
        logic [31:0] longitude_e7;
        logic [30:0] latitude_e7;
    } fix_report_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;

    nmea_gga_position_parser_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // parser state mirror
    logic [2:0]  pfx_cnt;
    logic        in_gga;
    logic [3:0]  fld_no;
    logic [31:0] int_acc;
    logic [23:0] frac_acc;
    logic [2:0]  frac_cnt;
    logic [2:0]  flags;
    logic signed [31:0] lat_q;
    logic signed [31:0] lon_q;
    logic signed [31:0] alt_q;
    logic [3:0]  fix_q;
    logic [6:0]  sats_q;

    fix_report_t expected_reports[$];
    int          fail_count;
    int          recv_mode;
    int          send_mode;
    bit          hold_rx;

    byte unsigned line_buf[$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [63:0] pow10(input int k);
        logic [63:0] p;
        p = 1;
        for (int i = 0; i < k; i++) p = p * 10;
        return p;
    endfunction

    // ddmm.mmmmm to 1e-7 degrees, truncated and saturated
    function automatic logic signed [31:0] to_e7(input logic [63:0] limit);
        logic [63:0] fr;
        logic [63:0] mins;
        logic [63:0] e7;
        fr = frac_acc;
        if (frac_cnt < FRACTION_DIGITS_DEF) fr = fr * pow10(FRACTION_DIGITS_DEF - frac_cnt);
        mins = (int_acc % 100) * pow10(FRACTION_DIGITS_DEF) + fr;
        e7 = (int_acc / 100) * 64'd10000000
            + mins * 64'd10000000 / (64'd60 * pow10(FRACTION_DIGITS_DEF));
        if (e7 > limit) e7 = limit;
        return e7[31:0];
    endfunction

    function automatic void close_field();
        logic [63:0] dm;
        case (fld_no)
            FLD_LAT: if (flags[1]) lat_q = to_e7(64'd900000000);
            FLD_LON: if (flags[1]) lon_q = to_e7(64'd1800000000);
            FLD_FIX: fix_q = (int_acc > 15) ? 4'd15 : int_acc[3:0];
            FLD_SATS: sats_q = (int_acc > 99) ? 7'd99 : int_acc[6:0];
            FLD_ALT: begin
                dm = int_acc * 64'd10;
                if (frac_cnt > 0) dm = dm + frac_acc / pow10(frac_cnt - 1);
                if (flags[2]) alt_q = (dm > 100000) ? -32'sd100000 : -$signed(dm[31:0]);
                else alt_q = (dm > 1000000) ? 32'sd1000000 : $signed(dm[31:0]);
            end
            default: ;
        endcase
    endfunction

    function automatic void clear_acc();
        int_acc = 0;
        frac_acc = 0;
        frac_cnt = 0;
        flags = 0;
    endfunction

    function automatic logic [7:0] prefix_at(input logic [2:0] i);
        case (i)
            3'd0: return "$";
            3'd1: return "G";
            3'd2: return "N";
            3'd3: return "G";
            3'd4: return "G";
            default: return "A";
        endcase
    endfunction

    // advance the parser mirror by one byte, queue a report at line end
    function automatic void predict_byte(input logic [7:0] b);
        logic [63:0] t;
        fix_report_t r;
        logic signed [31:0] m;
        if (b == CH_CR || b == CH_LF) begin
            if (in_gga) begin
                close_field();
                r.latitude_e7 = lat_q[30:0];
                r.longitude_e7 = lon_q;
                r.altitude_dm = alt_q[20:0];
                r.fix_mode = fix_q;
                r.satellites = sats_q;
                r.fix_valid = (fix_q != 0);
                expected_reports.push_back(r);
            end
            pfx_cnt = 0;
            in_gga = 0;
            fld_no = 0;
            clear_acc();
        end else if (!in_gga) begin
            if (pfx_cnt < PFX_LEN && b == prefix_at(pfx_cnt)) begin
                pfx_cnt++;
                if (pfx_cnt == PFX_LEN) begin
                    in_gga = 1;
                    fld_no = 0;
                    clear_acc();
                end
            end else begin
                pfx_cnt = PFX_SKIP;
            end
        end else if (b == CH_COMMA) begin
            close_field();
            if (fld_no < FLD_MAX) fld_no++;
            clear_acc();
        end else if (fld_no == FLD_LAT_HEM || fld_no == FLD_LON_HEM) begin
            if (!flags[2]) begin
                flags[2] = 1;
                if (fld_no == FLD_LAT_HEM) begin
                    m = (lat_q < 0) ? -lat_q : lat_q;
                    lat_q = (b == CH_SOUTH) ? -m : m;
                end else begin
                    m = (lon_q < 0) ? -lon_q : lon_q;
                    lon_q = (b == CH_WEST) ? -m : m;
                end
            end
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            if (!flags[0]) begin
                t = int_acc * 64'd10 + (b - CH_ZERO);
                int_acc = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
            end else if (frac_cnt < FRACTION_DIGITS_DEF) begin
                frac_acc = frac_acc * 10 + (b - CH_ZERO);
                frac_cnt++;
            end
            flags[1] = 1;
        end else if (b == CH_POINT) begin
            flags[0] = 1;
        end else if (b == CH_MINUS) begin
            flags[2] = 1;
        end
    endfunction

    // one byte transfer with random sender gaps
    task automatic send_byte(input logic [7:0] b);
        while (send_mode == 0 && $urandom_range(99) < 7 ||
               send_mode == 1 && $urandom_range(99) < 69) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_byte(b);
        @(negedge aclk);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_byte(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic put_digits(input int n);
        for (int i = 0; i < n; i++) line_buf.push_back(8'(8'h30 + $urandom_range(9)));
    endtask

    // random sentence, mostly well formed
    task automatic build_sentence();
        int kind;
        kind = $urandom_range(99);
        if (kind < 8) begin
            put_str("$GPRMC,1,2");
        end else if (kind < 14) begin
            for (int i = 0; i < $urandom_range(1, 12); i++)
                line_buf.push_back(8'($urandom_range(255)));
        end else begin
            put_str("$GNGGA,");
            put_digits($urandom_range(0, 6));
            put_str(",");
            if ($urandom_range(9) > 0) begin
                put_digits($urandom_range(1, 5));
                if ($urandom_range(3) > 0) begin
                    put_str(".");
                    put_digits($urandom_range(0, 8));
                end
            end
            put_str(",");
            case ($urandom_range(3))
                0: put_str("N");
                1: put_str("S");
                2: line_buf.push_back(8'($urandom_range(255)));
                default: ;
            endcase
            put_str(",");
            if ($urandom_range(9) > 0) begin
                put_digits($urandom_range(1, 6));
                put_str(".");
                put_digits($urandom_range(0, 8));
            end
            put_str(",");
            case ($urandom_range(3))
                0: put_str("E");
                1: put_str("W");
                2: line_buf.push_back(8'($urandom_range(255)));
                default: ;
            endcase
            put_str(",");
            put_digits($urandom_range(0, 2));
            put_str(",");
            put_digits($urandom_range(0, 3));
            put_str(",");
            put_digits($urandom_range(0, 2));
            put_str(",");
            if ($urandom_range(2) == 0) put_str("-");
            put_digits($urandom_range(0, 7));
            if ($urandom_range(3) > 0) begin
                put_str(".");
                put_digits($urandom_range(0, 3));
            end
            if ($urandom_range(4) == 0) line_buf.push_back(8'($urandom_range(255)));
            for (int i = 0; i < $urandom_range(0, 9); i++) put_str(",M");
        end
        line_buf.push_back($urandom_range(1) ? CH_CR : CH_LF);
    endtask

    task automatic wait_drain();
        while (expected_reports.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // directed lines; a typed check where the result is obvious
    typedef struct {
        string       text;
        bit          typed;
        fix_report_t want;
    } line_row_t;

    line_row_t dir_rows[$];

    task automatic run_directed();
        dir_rows = '{
            '{"$GNGGA,\n", 1'b1, '0},
            '{"$GPGGA,1,2,3\r", 1'b0, '0},
            '{"$GNGGA,,9000.00000,N,18000.00000,E,1,12,,100.25\r", 1'b0, '0},
            '{"$GNGGA,,9959.99999,S,99999.99999,W,99,999,,99999999\n", 1'b0, '0},
            '{"$GNGGA,,,x,,y,0,0,,-99999999\n", 1'b0, '0},
            '{"$GNGGA,,,,,,,,,-1.2.34-\r", 1'b0, '0},
            '{"$GNGGA,,4512.3456789x,n,00012,w,4,05,,1.9\r", 1'b0, '0},
            '{"$GNGGA,,99999999999,,,,15,99,,1000000.0,,,,,,,,,,\n", 1'b0, '0},
            '{"$GNGG$GNGGA,1\n", 1'b0, '0},
            '{"\r\n", 1'b0, '0},
            '{"$GNGGA,,0,N,0,E,,,,\n", 1'b0, '0}
        };
        foreach (dir_rows[i]) begin
            put_str(dir_rows[i].text);
            send_line();
            if (dir_rows[i].typed) begin
                // after reset everything reads zero
                if (expected_reports.size() == 0) begin
                    $error("typed row %0d: no report predicted", i);
                    fail_count++;
                end else if (expected_reports[$] != dir_rows[i].want) begin
                    $error("typed row %0d: report exp %h got %h", i, dir_rows[i].want,
                        expected_reports[$]);
                    fail_count++;
                end
            end
        end
        // every byte value but CR and LF once, mixed into a gga line
        put_str("$GNGGA,,");
        for (int v = 0; v < 256; v++)
            if (v != CH_CR && v != CH_LF) line_buf.push_back(8'(v));
        line_buf.push_back(CH_LF);
        send_line();
    endtask

    // result checker
    always @(posedge aclk) begin
        fix_report_t got;
        fix_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_reports.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                if (got.latitude_e7 !== want.latitude_e7) begin
                    $error("latitude_e7 exp %0d got %0d", $signed(want.latitude_e7),
                        $signed(got.latitude_e7));
                    fail_count++;
                end
                if (got.longitude_e7 !== want.longitude_e7) begin
                    $error("longitude_e7 exp %0d got %0d", $signed(want.longitude_e7),
                        $signed(got.longitude_e7));
                    fail_count++;
                end
                if (got.altitude_dm !== want.altitude_dm) begin
                    $error("altitude_dm exp %0d got %0d", $signed(want.altitude_dm),
                        $signed(got.altitude_dm));
                    fail_count++;
                end
                if (got.fix_mode !== want.fix_mode) begin
                    $error("fix_mode exp %0d got %0d", want.fix_mode, got.fix_mode);
                    fail_count++;
                end
                if (got.satellites !== want.satellites) begin
                    $error("satellites exp %0d got %0d", want.satellites, got.satellites);
                    fail_count++;
                end
                if (got.fix_valid !== want.fix_valid) begin
                    $error("fix_valid exp %0d got %0d", want.fix_valid, got.fix_valid);
                    fail_count++;
                end
            end
        end
    end

    // receiver ready with random stalls and a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (hold_rx) m_tready <= 1'b0;
        else if (recv_mode == 0) m_tready <= ($urandom_range(99) >= 69);
        else if (recv_mode == 1) m_tready <= ($urandom_range(99) >= 7);
        else m_tready <= 1'b1;
    end

    initial begin
        int sent;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        m_tready = 1'b0;
        hold_rx = 0;
        recv_mode = 0;
        send_mode = 0;
        fail_count = 0;
        pfx_cnt = 0;
        in_gga = 0;
        fld_no = 0;
        clear_acc();
        lat_q = 0;
        lon_q = 0;
        alt_q = 0;
        fix_q = 0;
        sats_q = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();

        // long receiver hold-off while short gga lines keep coming
        hold_rx = 1;
        fork
            begin
                repeat (400) @(negedge aclk);
                hold_rx = 0;
            end
            begin
                for (int i = 0; i < 8; i++) begin
                    put_str("$GNGGA,,1,S,2,W,3,4,,5\n");
                    send_line();
                end
            end
        join
        // sender pauses until all results are back
        s_tvalid <= 1'b0;
        wait_drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_mode = ph;
            recv_mode = ph;
            sent = 0;
            while (sent < 150) begin
                build_sentence();
                sent += line_buf.size();
                send_line();
            end
        end
        s_tvalid <= 1'b0;

        wait_drain();
        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
